>>> design/voxel_face_culling_mesher_unit_macros.svh
// Assertion macros shared by the mesher's checker.
`ifndef VOXEL_FACE_CULLING_MESHER_UNIT_MACROS_SVH
`define VOXEL_FACE_CULLING_MESHER_UNIT_MACROS_SVH

// Same-cycle implication.
`define VFCM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mesher assertion failed");

// Next-cycle implication.
`define VFCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mesher assertion failed");

`endif

>>> design/vfcm_pkg.sv
// Types, constants, microcode and tables of the voxel face-culling mesher.
package vfcm_pkg;

   localparam int GRID_X    = 4;
   localparam int GRID_Y    = 4;
   localparam int GRID_Z    = 4;
   localparam int CELLS     = GRID_X * GRID_Y * GRID_Z;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int CW        = 2;
   localparam int XW        = CW + 1;
   localparam int FACES     = 6;
   localparam int VERTS     = 6;
   localparam int UPC_W     = 4;

   localparam logic [2:0] VERT_LAST = 3'(VERTS - 1);

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_MESH  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   typedef enum logic [2:0] {
      FACE_FRONT  = 3'd0,
      FACE_BACK   = 3'd1,
      FACE_TOP    = 3'd2,
      FACE_BOTTOM = 3'd3,
      FACE_LEFT   = 3'd4,
      FACE_RIGHT  = 3'd5
   } face_type;

   // microprogram addresses
   localparam logic [UPC_W-1:0] S_IDLE = 4'd0;
   localparam logic [UPC_W-1:0] S_WR   = 4'd1;
   localparam logic [UPC_W-1:0] S_Q0   = 4'd2;
   localparam logic [UPC_W-1:0] S_Q1   = 4'd3;
   localparam logic [UPC_W-1:0] S_M0   = 4'd4;
   localparam logic [UPC_W-1:0] S_M1   = 4'd5;
   localparam logic [UPC_W-1:0] S_M2   = 4'd6;
   localparam logic [UPC_W-1:0] S_M3   = 4'd7;
   localparam logic [UPC_W-1:0] S_M4   = 4'd8;
   localparam logic [UPC_W-1:0] S_M5   = 4'd9;
   localparam logic [UPC_W-1:0] S_M6   = 4'd10;
   localparam logic [UPC_W-1:0] S_M7   = 4'd11;
   localparam logic [UPC_W-1:0] S_M8   = 4'd12;
   localparam logic [UPC_W-1:0] S_EMIT = 4'd13;

   typedef enum logic [2:0] {
      RD_CENTER = 3'd0,
      RD_PZ     = 3'd1,
      RD_NZ     = 3'd2,
      RD_PY     = 3'd3,
      RD_NY     = 3'd4,
      RD_NX     = 3'd5,
      RD_PX     = 3'd6,
      RD_NONE   = 3'd7
   } rd_sel_type;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_WRITE = 3'd1,
      OP_QUERY = 3'd2,
      OP_FIRST = 3'd3,
      OP_EMIT  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      J_NEXT     = 3'd0,
      J_DISPATCH = 3'd1,
      J_GOTO     = 3'd2,
      J_IF_OFF   = 3'd3,
      J_IF_NONE  = 3'd4,
      J_WAIT_OUT = 3'd5,
      J_EMIT     = 3'd6
   } jmp_type;

   typedef struct packed {
      rd_sel_type       rd_sel;
      logic             cap_en;
      logic [2:0]       cap_idx;
      op_type           op;
      jmp_type          jmp;
      logic [UPC_W-1:0] target;
   } ctl_type;

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CW-1:0] z;
      logic          oob;
   } coord_type;

   typedef struct packed {
      logic [CW-1:0] out_x;
      logic [CW-1:0] out_y;
      logic [CW-1:0] out_z;
      logic [2:0]    face;
      logic          corner_x_pos;
      logic          corner_y_pos;
      logic          corner_z_pos;
      logic          tex_u;
      logic          tex_v;
      logic          is_active;
      logic          last;
   } rsp_type;

   // corner code: bit 2 x plus, bit 1 y plus, bit 0 z plus
   localparam logic [2:0] FACE_CORNERS [FACES][VERTS] = '{
      '{3'd1, 3'd5, 3'd7, 3'd7, 3'd3, 3'd1},
      '{3'd2, 3'd6, 3'd4, 3'd4, 3'd0, 3'd2},
      '{3'd3, 3'd7, 3'd6, 3'd6, 3'd2, 3'd3},
      '{3'd0, 3'd4, 3'd5, 3'd5, 3'd1, 3'd0},
      '{3'd0, 3'd1, 3'd3, 3'd3, 3'd2, 3'd0},
      '{3'd5, 3'd4, 3'd6, 3'd6, 3'd7, 3'd5}
   };
   localparam logic TEX_U [VERTS] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
   localparam logic TEX_V [VERTS] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

   function automatic ctl_type ucode(input logic [UPC_W-1:0] step);
      ctl_type c;
      case (step)
         S_IDLE:  c = '{RD_NONE,   1'b0, 3'd0,        OP_NONE,  J_DISPATCH, S_IDLE};
         S_WR:    c = '{RD_NONE,   1'b0, 3'd0,        OP_WRITE, J_GOTO,     S_IDLE};
         S_Q0:    c = '{RD_CENTER, 1'b0, 3'd0,        OP_NONE,  J_NEXT,     S_IDLE};
         S_Q1:    c = '{RD_CENTER, 1'b0, 3'd0,        OP_QUERY, J_WAIT_OUT, S_IDLE};
         S_M0:    c = '{RD_CENTER, 1'b0, 3'd0,        OP_NONE,  J_NEXT,     S_IDLE};
         S_M1:    c = '{RD_PZ,     1'b0, 3'd0,        OP_NONE,  J_IF_OFF,   S_IDLE};
         S_M2:    c = '{RD_NZ,     1'b1, FACE_FRONT,  OP_NONE,  J_NEXT,     S_IDLE};
         S_M3:    c = '{RD_PY,     1'b1, FACE_BACK,   OP_NONE,  J_NEXT,     S_IDLE};
         S_M4:    c = '{RD_NY,     1'b1, FACE_TOP,    OP_NONE,  J_NEXT,     S_IDLE};
         S_M5:    c = '{RD_NX,     1'b1, FACE_BOTTOM, OP_NONE,  J_NEXT,     S_IDLE};
         S_M6:    c = '{RD_PX,     1'b1, FACE_LEFT,   OP_NONE,  J_NEXT,     S_IDLE};
         S_M7:    c = '{RD_NONE,   1'b1, FACE_RIGHT,  OP_NONE,  J_NEXT,     S_IDLE};
         S_M8:    c = '{RD_NONE,   1'b0, 3'd0,        OP_FIRST, J_IF_NONE,  S_IDLE};
         S_EMIT:  c = '{RD_NONE,   1'b0, 3'd0,        OP_EMIT,  J_EMIT,     S_IDLE};
         default: c = '{RD_NONE,   1'b0, 3'd0,        OP_NONE,  J_GOTO,     S_IDLE};
      endcase
      return c;
   endfunction

   function automatic logic [UPC_W-1:0] dispatch(input logic [1:0] cmd);
      logic [UPC_W-1:0] s;
      case (cmd)
         CMD_WRITE: s = S_WR;
         CMD_MESH:  s = S_M0;
         CMD_QUERY: s = S_Q0;
         default:   s = S_IDLE;
      endcase
      return s;
   endfunction

   function automatic logic in_grid(input logic [XW-1:0] x, input logic [XW-1:0] y,
                                    input logic [XW-1:0] z);
      return (int'(x) < GRID_X) && (int'(y) < GRID_Y) && (int'(z) < GRID_Z);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [CW-1:0] x,
                                                   input logic [CW-1:0] y,
                                                   input logic [CW-1:0] z);
      return ADDR_W'((int'(x) * GRID_Y + int'(y)) * GRID_Z + int'(z));
   endfunction

   function automatic logic [2:0] first_face(input logic [FACES-1:0] m);
      logic [2:0] r;
      r = 3'd0;
      for (int i = FACES - 1; i >= 0; i--) begin
         if (m[i]) r = 3'(i);
      end
      return r;
   endfunction

endpackage

>>> design/vfcm_grid.sv
// Occupancy memory: one bit per cell, registered read, reset image via valid bits.
module vfcm_grid import vfcm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  coord_type rd_coord,
   input  logic      wr_en,
   input  coord_type wr_coord,
   input  logic      wr_bit,
   output logic      rd_bit
);

   logic              mem_ff [CELLS];
   logic [CELLS-1:0]  valid_ff;
   logic              rd_bit_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_go;

   assign rd_addr = cell_addr(rd_coord.x, rd_coord.y, rd_coord.z);
   assign wr_addr = cell_addr(wr_coord.x, wr_coord.y, wr_coord.z);
   assign wr_go   = wr_en && !wr_coord.oob;

   always_ff @(posedge clock) begin
      if (wr_go) begin
         mem_ff[wr_addr] <= wr_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_go) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // unwritten cells read as the reset image: bottom layer set
   always_ff @(posedge clock) begin
      if (rd_coord.oob) begin
         rd_bit_ff <= 1'b0;
      end else if (valid_ff[rd_addr]) begin
         rd_bit_ff <= mem_ff[rd_addr];
      end else begin
         rd_bit_ff <= (rd_coord.y == '0);
      end
   end

   assign rd_bit = rd_bit_ff;

endmodule

>>> design/vfcm_seq.sv
// Microcoded sequencer and datapath: neighbour reads, face exposure, vertex walk.
module vfcm_seq import vfcm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_cmd,
   input  logic [CW-1:0] req_cell_x,
   input  logic [CW-1:0] req_cell_y,
   input  logic [CW-1:0] req_cell_z,
   input  logic          req_active_in,
   output logic          req_stall,
   input  logic          out_free,
   output logic          emit_valid,
   output rsp_type       emit,
   output coord_type     rd_coord,
   output logic          wr_en,
   output coord_type     wr_coord,
   output logic          wr_bit,
   input  logic          rd_bit
);

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CW-1:0] z;
      logic          bit_val;
   } item_type;

   logic [UPC_W-1:0] upc_ff, upc_in;
   item_type         item_ff, item_in;
   logic [FACES-1:0] exp_ff, exp_in;
   logic [2:0]       face_ff, face_in;
   logic [2:0]       vcnt_ff, vcnt_in;
   ctl_type          ctl;
   logic             accept;
   logic [FACES-1:0] rem;
   logic             last_vtx;
   logic [XW-1:0]    ex, ey, ez;

   assign ctl       = ucode(upc_ff);
   assign req_stall = (ctl.jmp != J_DISPATCH);
   assign accept    = (ctl.jmp == J_DISPATCH) && req_valid;

   always_comb begin
      for (int i = 0; i < FACES; i++) begin
         rem[i] = exp_ff[i] && (3'(i) > face_ff);
      end
   end

   assign last_vtx = (vcnt_ff == VERT_LAST) && (rem == '0);

   // neighbour address
   always_comb begin
      ex = {1'b0, item_ff.x};
      ey = {1'b0, item_ff.y};
      ez = {1'b0, item_ff.z};
      case (ctl.rd_sel)
         RD_PZ:   ez = ez + XW'(1);
         RD_NZ:   ez = ez - XW'(1);
         RD_PY:   ey = ey + XW'(1);
         RD_NY:   ey = ey - XW'(1);
         RD_NX:   ex = ex - XW'(1);
         RD_PX:   ex = ex + XW'(1);
         default: ;
      endcase
      rd_coord.x   = ex[CW-1:0];
      rd_coord.y   = ey[CW-1:0];
      rd_coord.z   = ez[CW-1:0];
      rd_coord.oob = !in_grid(ex, ey, ez);
   end

   assign wr_en        = (ctl.op == OP_WRITE);
   assign wr_coord.x   = item_ff.x;
   assign wr_coord.y   = item_ff.y;
   assign wr_coord.z   = item_ff.z;
   assign wr_coord.oob = !in_grid({1'b0, item_ff.x}, {1'b0, item_ff.y}, {1'b0, item_ff.z});
   assign wr_bit       = item_ff.bit_val;

   always_comb begin
      emit       = '0;
      emit.out_x = item_ff.x;
      emit.out_y = item_ff.y;
      emit.out_z = item_ff.z;
      emit_valid = 1'b0;
      case (ctl.op)
         OP_QUERY: begin
            emit_valid     = out_free;
            emit.is_active = rd_bit;
            emit.last      = 1'b1;
         end
         OP_EMIT: begin
            emit_valid        = out_free;
            emit.face         = face_ff;
            emit.corner_x_pos = FACE_CORNERS[face_ff][vcnt_ff][2];
            emit.corner_y_pos = FACE_CORNERS[face_ff][vcnt_ff][1];
            emit.corner_z_pos = FACE_CORNERS[face_ff][vcnt_ff][0];
            emit.tex_u        = TEX_U[vcnt_ff];
            emit.tex_v        = TEX_V[vcnt_ff];
            emit.last         = last_vtx;
         end
         default: ;
      endcase
   end

   always_comb begin
      upc_in  = upc_ff + UPC_W'(1);
      item_in = item_ff;
      exp_in  = exp_ff;
      face_in = face_ff;
      vcnt_in = vcnt_ff;

      case (ctl.jmp)
         J_NEXT:     upc_in = upc_ff + UPC_W'(1);
         J_DISPATCH: upc_in = req_valid ? dispatch(req_cmd) : upc_ff;
         J_GOTO:     upc_in = ctl.target;
         J_IF_OFF:   if (!rd_bit) upc_in = ctl.target;
         J_IF_NONE:  if (exp_ff == '0) upc_in = ctl.target;
         J_WAIT_OUT: upc_in = out_free ? ctl.target : upc_ff;
         J_EMIT:     upc_in = (out_free && last_vtx) ? ctl.target : upc_ff;
         default:    upc_in = S_IDLE;
      endcase

      if (accept) begin
         item_in = '{req_cell_x, req_cell_y, req_cell_z, req_active_in};
      end

      if (ctl.cap_en) begin
         exp_in[ctl.cap_idx] = !rd_bit;
      end

      if (ctl.op == OP_FIRST) begin
         face_in = first_face(exp_ff);
         vcnt_in = 3'd0;
      end else if (ctl.op == OP_EMIT && out_free) begin
         if (vcnt_ff == VERT_LAST) begin
            vcnt_in = 3'd0;
            face_in = first_face(rem);
         end else begin
            vcnt_in = vcnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff  <= S_IDLE;
         exp_ff  <= '0;
         face_ff <= 3'd0;
         vcnt_ff <= 3'd0;
      end else begin
         upc_ff  <= upc_in;
         exp_ff  <= exp_in;
         face_ff <= face_in;
         vcnt_ff <= vcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

>>> design/voxel_face_culling_mesher_unit.sv
// Top level of the voxel face-culling mesher: sequencer, occupancy memory, result register.
//
// Request channel (req_*): one item per handshake, cmd 0 writes a cell's occupancy
// bit, 1 meshes a cell, 2 queries a cell. An item is taken when req_valid is high
// and req_stall low; req_stall is low only while the sequencer waits for an item.
// Result channel (rsp_*): vertices or the query answer, one per cycle at best,
// rsp_last on the final result of an item. Writes and code 3 give no result.
// Steps, from acceptance: a write updates the memory; a query reads the cell, and
// its answer goes to the output register; a mesh item reads the cell and its six
// neighbours through the single memory read port, then streams 6 vertices per
// exposed face, and gives no result for an inactive cell.
// A stalled result holds in the output register; the vertex walk pauses until it
// is taken, so nothing is lost. Reset returns the sequencer to its idle step,
// empties the output register and restores the occupancy image (bottom layer
// set, all else clear) at once through per-cell valid bits; no clearing pass.
module voxel_face_culling_mesher_unit import vfcm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_cmd,
   input  logic [CW-1:0] req_cell_x,
   input  logic [CW-1:0] req_cell_y,
   input  logic [CW-1:0] req_cell_z,
   input  logic          req_active_in,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [CW-1:0] rsp_out_x,
   output logic [CW-1:0] rsp_out_y,
   output logic [CW-1:0] rsp_out_z,
   output logic [2:0]    rsp_face,
   output logic          rsp_corner_x_pos,
   output logic          rsp_corner_y_pos,
   output logic          rsp_corner_z_pos,
   output logic          rsp_tex_u,
   output logic          rsp_tex_v,
   output logic          rsp_is_active,
   output logic          rsp_last
);

   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff;
   logic      out_free;
   logic      emit_valid;
   rsp_type   emit;
   coord_type rd_coord;
   coord_type wr_coord;
   logic      wr_en;
   logic      wr_bit;
   logic      rd_bit;

   vfcm_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_cmd       (req_cmd),
      .req_cell_x    (req_cell_x),
      .req_cell_y    (req_cell_y),
      .req_cell_z    (req_cell_z),
      .req_active_in (req_active_in),
      .req_stall     (req_stall),
      .out_free      (out_free),
      .emit_valid    (emit_valid),
      .emit          (emit),
      .rd_coord      (rd_coord),
      .wr_en         (wr_en),
      .wr_coord      (wr_coord),
      .wr_bit        (wr_bit),
      .rd_bit        (rd_bit)
   );

   vfcm_grid u_grid (
      .clock    (clock),
      .reset    (reset),
      .rd_coord (rd_coord),
      .wr_en    (wr_en),
      .wr_coord (wr_coord),
      .wr_bit   (wr_bit),
      .rd_bit   (rd_bit)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit_valid) begin
         rsp_ff <= emit;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = rsp_ff.out_x;
   assign rsp_out_y        = rsp_ff.out_y;
   assign rsp_out_z        = rsp_ff.out_z;
   assign rsp_face         = rsp_ff.face;
   assign rsp_corner_x_pos = rsp_ff.corner_x_pos;
   assign rsp_corner_y_pos = rsp_ff.corner_y_pos;
   assign rsp_corner_z_pos = rsp_ff.corner_z_pos;
   assign rsp_tex_u        = rsp_ff.tex_u;
   assign rsp_tex_v        = rsp_ff.tex_v;
   assign rsp_is_active    = rsp_ff.is_active;
   assign rsp_last         = rsp_ff.last;

endmodule

>>> design/vfcm_checker.sv
// Port-level checker for the mesher, bound to the top level.
`include "voxel_face_culling_mesher_unit_macros.svh"

module vfcm_checker import vfcm_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input logic [CW-1:0] rsp_out_x,
   input logic [CW-1:0] rsp_out_y,
   input logic [CW-1:0] rsp_out_z,
   input logic [2:0]    rsp_face,
   input logic          rsp_corner_x_pos,
   input logic          rsp_corner_y_pos,
   input logic          rsp_corner_z_pos,
   input logic          rsp_tex_u,
   input logic          rsp_tex_v,
   input logic          rsp_is_active,
   input logic          rsp_last
);

   logic [15:0] rsp_word;
   logic        rsp_bare;

   assign rsp_word = {rsp_out_x, rsp_out_y, rsp_out_z, rsp_face, rsp_corner_x_pos,
                      rsp_corner_y_pos, rsp_corner_z_pos, rsp_tex_u, rsp_tex_v,
                      rsp_is_active, rsp_last};
   assign rsp_bare = (rsp_face == '0) && !rsp_tex_u && !rsp_tex_v;

   // a stalled result holds
   `VFCM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

   // out of reset the block is idle and empty
   `VFCM_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !req_stall && !rsp_valid)

   // a new item is only taken once the previous run has reached its last result
   `VFCM_ASSERT_IMPL(a_no_overlap, clock, reset, req_valid && !req_stall, !rsp_valid || rsp_last)

   // a query answer that reports an active cell is a single, bare result
   `VFCM_ASSERT_IMPL(a_query_shape, clock, reset, rsp_valid && rsp_is_active, rsp_last && rsp_bare)

   `VFCM_ASSERT_IMPL(a_face_range, clock, reset, rsp_valid, rsp_face <= FACE_RIGHT)

endmodule

bind voxel_face_culling_mesher_unit vfcm_checker u_vfcm_checker (.*);
